### rtl/ptsn_pkg.sv
// ----------------------------------------------------------------------------
// ptsn_pkg
// Types, widths and codes shared by the point-to-segment nearest pipeline.
// ----------------------------------------------------------------------------
package ptsn_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned DW    = CoordBits + 1;     // coordinate difference
  localparam int unsigned PW    = 2 * DW;            // product of differences
  localparam int unsigned DapW  = PW + 1;            // signed dot product
  localparam int unsigned DabW  = PW;                // squared length
  localparam int unsigned LoW   = DW + 1;            // low slice of |dap|
  localparam int unsigned HiW   = PW - LoW;          // high slice of |dap|
  localparam int unsigned NumW  = DW + PW;           // dividend
  localparam int unsigned QB    = CoordBits + 4;     // quotient bits
  localparam int unsigned RW    = DabW + 1;          // divider remainder
  localparam int unsigned NW    = CoordBits + 4;     // unsaturated point
  localparam int unsigned SR    = NW;                // root bits
  localparam int unsigned VW    = 2 * SR;            // radicand
  localparam int unsigned SRW   = SR + 3;            // root remainder
  localparam int unsigned DistW = CoordBits + 1;

  typedef enum logic [1:0] {
    CaseInterior   = 2'd0,
    CaseClampA     = 2'd1,
    CaseClampB     = 2'd2,
    CaseDegenerate = 2'd3
  } case_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
    logic                        clamp_to_segment;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] nearest_x;
    logic signed [CoordBits-1:0] nearest_y;
    logic        [DistW-1:0]     distance;
    logic        [1:0]           case_code;
  } out_beat_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] base_x;
    logic signed [CoordBits-1:0] base_y;
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
    logic                        neg_x;
    logic                        neg_y;
    case_e                       code;
  } side_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t       x;
    div_lane_t       y;
    logic [DabW-1:0] dab;
    side_t           side;
  } div_stage_t;

  typedef struct packed {
    logic        [SRW-1:0] rem;
    logic        [SR-1:0]  root;
    logic        [VW-1:0]  rad;
    logic signed [NW-1:0]  nx;
    logic signed [NW-1:0]  ny;
    case_e                 code;
  } sqrt_stage_t;

endpackage

### rtl/ptsn_front.sv
// ----------------------------------------------------------------------------
// ptsn_front
// Differences, dot products, case decision and dividend partial products.
// ----------------------------------------------------------------------------
module ptsn_front import ptsn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  in_beat_t   beat_i,
  output logic       valid_o,
  output div_stage_t stage_o
);

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    in_beat_t             beat;
  } s1_t;

  typedef struct packed {
    logic signed [PW-1:0] pxdx;
    logic signed [PW-1:0] pydy;
    logic signed [PW-1:0] dxdx;
    logic signed [PW-1:0] dydy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    in_beat_t             beat;
  } s2_t;

  typedef struct packed {
    logic signed [DapW-1:0] dap;
    logic        [DabW-1:0] dab;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    in_beat_t               beat;
  } s3_t;

  typedef struct packed {
    logic [DW+LoW-1:0] ppx_lo;
    logic [DW+HiW-1:0] ppx_hi;
    logic [DW+LoW-1:0] ppy_lo;
    logic [DW+HiW-1:0] ppy_hi;
    logic [DabW-1:0]   dab;
    side_t             side;
  } s4_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  logic [3:0] vld_q;

  logic [PW-1:0]   dap_mag;
  logic [DW-1:0]   abs_dx, abs_dy;
  logic            dap_le0, dap_ge;
  logic [NumW-1:0] num_x, num_y;

  always_comb begin
    s1_d.beat = beat_i;
    s1_d.dx = {beat_i.end_x[CoordBits-1], beat_i.end_x}
            - {beat_i.start_x[CoordBits-1], beat_i.start_x};
    s1_d.dy = {beat_i.end_y[CoordBits-1], beat_i.end_y}
            - {beat_i.start_y[CoordBits-1], beat_i.start_y};
    s1_d.px = {beat_i.query_x[CoordBits-1], beat_i.query_x}
            - {beat_i.start_x[CoordBits-1], beat_i.start_x};
    s1_d.py = {beat_i.query_y[CoordBits-1], beat_i.query_y}
            - {beat_i.start_y[CoordBits-1], beat_i.start_y};
  end

  always_comb begin
    s2_d.pxdx = s1_q.px * s1_q.dx;
    s2_d.pydy = s1_q.py * s1_q.dy;
    s2_d.dxdx = s1_q.dx * s1_q.dx;
    s2_d.dydy = s1_q.dy * s1_q.dy;
    s2_d.dx   = s1_q.dx;
    s2_d.dy   = s1_q.dy;
    s2_d.beat = s1_q.beat;
  end

  always_comb begin
    s3_d.dap  = DapW'(s2_q.pxdx) + DapW'(s2_q.pydy);
    s3_d.dab  = $unsigned(s2_q.dxdx) + $unsigned(s2_q.dydy);
    s3_d.dx   = s2_q.dx;
    s3_d.dy   = s2_q.dy;
    s3_d.beat = s2_q.beat;
  end

  always_comb begin
    logic [DapW-1:0] neg_dap;
    neg_dap = -s3_q.dap;
    dap_mag = s3_q.dap[DapW-1] ? neg_dap[PW-1:0] : s3_q.dap[PW-1:0];
    abs_dx  = s3_q.dx[DW-1] ? -s3_q.dx : s3_q.dx;
    abs_dy  = s3_q.dy[DW-1] ? -s3_q.dy : s3_q.dy;
    dap_le0 = (s3_q.dap <= 0);
    dap_ge  = (s3_q.dap >= $signed({1'b0, s3_q.dab}));

    s4_d.ppx_lo = abs_dx * dap_mag[LoW-1:0];
    s4_d.ppx_hi = abs_dx * dap_mag[PW-1:LoW];
    s4_d.ppy_lo = abs_dy * dap_mag[LoW-1:0];
    s4_d.ppy_hi = abs_dy * dap_mag[PW-1:LoW];
    s4_d.dab    = s3_q.dab;

    s4_d.side.query_x = s3_q.beat.query_x;
    s4_d.side.query_y = s3_q.beat.query_y;
    s4_d.side.neg_x   = s3_q.dx[DW-1] ^ s3_q.dap[DapW-1];
    s4_d.side.neg_y   = s3_q.dy[DW-1] ^ s3_q.dap[DapW-1];
    s4_d.side.base_x  = s3_q.beat.start_x;
    s4_d.side.base_y  = s3_q.beat.start_y;
    priority if (s3_q.beat.clamp_to_segment && dap_le0) begin
      s4_d.side.code = CaseClampA;
    end else if (s3_q.beat.clamp_to_segment && dap_ge) begin
      s4_d.side.code   = CaseClampB;
      s4_d.side.base_x = s3_q.beat.end_x;
      s4_d.side.base_y = s3_q.beat.end_y;
    end else if (s3_q.dab == '0) begin
      s4_d.side.code = CaseDegenerate;
    end else begin
      s4_d.side.code = CaseInterior;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  always_comb begin
    num_x = NumW'(s4_q.ppx_lo) + (NumW'(s4_q.ppx_hi) << LoW);
    num_y = NumW'(s4_q.ppy_lo) + (NumW'(s4_q.ppy_hi) << LoW);
    stage_o.x.rem = RW'(num_x >> QB);
    stage_o.x.low = num_x[QB-1:0];
    stage_o.x.quo = '0;
    stage_o.y.rem = RW'(num_y >> QB);
    stage_o.y.low = num_y[QB-1:0];
    stage_o.y.quo = '0;
    stage_o.dab   = s4_q.dab;
    stage_o.side  = s4_q.side;
  end

  assign valid_o = vld_q[3];

endmodule

### rtl/ptsn_div_cell.sv
// ----------------------------------------------------------------------------
// ptsn_div_cell
// One restoring division step for both coordinate lanes.
// ----------------------------------------------------------------------------
module ptsn_div_cell import ptsn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  div_stage_t stage_i,
  output logic       valid_o,
  output div_stage_t stage_o
);

  div_stage_t stage_d, stage_q;
  logic       valid_q;

  function automatic div_lane_t step(div_lane_t l, logic [DabW-1:0] dab);
    div_lane_t     r;
    logic [RW-1:0] t;
    logic [RW-1:0] den;
    den = {1'b0, dab};
    t   = {l.rem[RW-2:0], l.low[QB-1]};
    r.low = {l.low[QB-2:0], 1'b0};
    if (t >= den) begin
      r.rem = t - den;
      r.quo = {l.quo[QB-2:0], 1'b1};
    end else begin
      r.rem = t;
      r.quo = {l.quo[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    stage_d      = stage_i;
    stage_d.x    = step(stage_i.x, stage_i.dab);
    stage_d.y    = step(stage_i.y, stage_i.dab);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/ptsn_mid.sv
// ----------------------------------------------------------------------------
// ptsn_mid
// Quotient rounding, foot point, error vector and squared distance.
// ----------------------------------------------------------------------------
module ptsn_mid import ptsn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  div_stage_t  stage_i,
  output logic        valid_o,
  output sqrt_stage_t stage_o
);

  typedef struct packed {
    logic signed [NW-1:0]        nx;
    logic signed [NW-1:0]        ny;
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
    case_e                       code;
  } m1_t;

  typedef struct packed {
    logic signed [NW-1:0] ex;
    logic signed [NW-1:0] ey;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    case_e                code;
  } m2_t;

  typedef struct packed {
    logic signed [VW-1:0] exx;
    logic signed [VW-1:0] eyy;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    case_e                code;
  } m3_t;

  m1_t m1_d, m1_q;
  m2_t m2_d, m2_q;
  m3_t m3_d, m3_q;
  sqrt_stage_t m4_d, m4_q;
  logic [3:0] vld_q;

  function automatic logic signed [NW-1:0] offset(div_lane_t l, logic [DabW-1:0] dab,
                                                   logic neg);
    logic          up;
    logic [QB:0]   qr;
    logic [NW-1:0] mag;
    up  = ({l.rem, 1'b0} >= {2'b00, dab});
    qr  = {1'b0, l.quo} + {{QB{1'b0}}, up};
    mag = NW'(qr);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  always_comb begin
    logic signed [NW-1:0] bx, by;
    bx = NW'(stage_i.side.base_x);
    by = NW'(stage_i.side.base_y);
    m1_d.query_x = stage_i.side.query_x;
    m1_d.query_y = stage_i.side.query_y;
    m1_d.code    = stage_i.side.code;
    if (stage_i.side.code == CaseInterior) begin
      m1_d.nx = bx + offset(stage_i.x, stage_i.dab, stage_i.side.neg_x);
      m1_d.ny = by + offset(stage_i.y, stage_i.dab, stage_i.side.neg_y);
    end else begin
      m1_d.nx = bx;
      m1_d.ny = by;
    end
  end

  always_comb begin
    m2_d.ex   = m1_q.nx - NW'(m1_q.query_x);
    m2_d.ey   = m1_q.ny - NW'(m1_q.query_y);
    m2_d.nx   = m1_q.nx;
    m2_d.ny   = m1_q.ny;
    m2_d.code = m1_q.code;
  end

  always_comb begin
    m3_d.exx  = m2_q.ex * m2_q.ex;
    m3_d.eyy  = m2_q.ey * m2_q.ey;
    m3_d.nx   = m2_q.nx;
    m3_d.ny   = m2_q.ny;
    m3_d.code = m2_q.code;
  end

  always_comb begin
    m4_d.rad  = $unsigned(m3_q.exx) + $unsigned(m3_q.eyy);
    m4_d.rem  = '0;
    m4_d.root = '0;
    m4_d.nx   = m3_q.nx;
    m4_d.ny   = m3_q.ny;
    m4_d.code = m3_q.code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
      m3_q <= m3_d;
      m4_q <= m4_d;
    end
  end

  assign valid_o = vld_q[3];
  assign stage_o = m4_q;

endmodule

### rtl/ptsn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ptsn_sqrt_cell
// One digit-by-digit square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module ptsn_sqrt_cell import ptsn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  sqrt_stage_t stage_i,
  output logic        valid_o,
  output sqrt_stage_t stage_o
);

  sqrt_stage_t stage_d, stage_q;
  logic        valid_q;

  always_comb begin
    logic [SRW-1:0] t;
    logic [SRW-1:0] trial;
    t       = {stage_i.rem[SRW-3:0], stage_i.rad[VW-1:VW-2]};
    trial   = {1'b0, stage_i.root, 2'b01};
    stage_d = stage_i;
    stage_d.rad = {stage_i.rad[VW-3:0], 2'b00};
    if (t >= trial) begin
      stage_d.rem  = t - trial;
      stage_d.root = {stage_i.root[SR-2:0], 1'b1};
    end else begin
      stage_d.rem  = t;
      stage_d.root = {stage_i.root[SR-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/point_to_segment_nearest.sv
// ----------------------------------------------------------------------------
// point_to_segment_nearest
// Nearest point on a segment or its line to a query point, with distance.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is accepted every clock unless a finished result
// waits on the output, which holds the whole pipe. Each beat passes the front
// section, the 28 divider cells that form the projection quotient, one bit
// per cell, the mid section, the 28 square root cells that form the distance,
// one bit per cell, and the output register; the pipe advances together.
module point_to_segment_nearest import ptsn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam logic signed [NW-1:0] CoordMax = NW'((2 ** (CoordBits - 1)) - 1);
  localparam logic signed [NW-1:0] CoordMin = -CoordMax - NW'(1);

  logic        en;
  logic        div_v  [QB+1];
  div_stage_t  div_s  [QB+1];
  logic        sq_v   [SR+1];
  sqrt_stage_t sq_s   [SR+1];

  out_beat_t out_d, out_q;
  logic      out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  ptsn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .beat_i  (in_beat_i),
    .valid_o (div_v[0]),
    .stage_o (div_s[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_div
    ptsn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[i]),
      .stage_i (div_s[i]),
      .valid_o (div_v[i+1]),
      .stage_o (div_s[i+1])
    );
  end

  ptsn_mid u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_v[QB]),
    .stage_i (div_s[QB]),
    .valid_o (sq_v[0]),
    .stage_o (sq_s[0])
  );

  for (genvar i = 0; i < SR; i++) begin : g_sqrt
    ptsn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .stage_i (sq_s[i]),
      .valid_o (sq_v[i+1]),
      .stage_o (sq_s[i+1])
    );
  end

  function automatic logic signed [CoordBits-1:0] sat(logic signed [NW-1:0] v);
    logic signed [NW-1:0] c;
    if (v > CoordMax) begin
      c = CoordMax;
    end else if (v < CoordMin) begin
      c = CoordMin;
    end else begin
      c = v;
    end
    return c[CoordBits-1:0];
  endfunction

  always_comb begin
    logic          up;
    logic [SR:0]   root_r;
    sqrt_stage_t   s;
    s      = sq_s[SR];
    up     = (s.rem > SRW'(s.root));
    root_r = {1'b0, s.root} + {{SR{1'b0}}, up};
    out_d.nearest_x = sat(s.nx);
    out_d.nearest_y = sat(s.ny);
    out_d.case_code = s.code;
    if (|root_r[SR:DistW]) begin
      out_d.distance = '1;
    end else begin
      out_d.distance = root_r[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_v[SR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

### test/ptsn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsn_checker
// Watches both channels of point_to_segment_nearest, computes the nearest
// point, distance and case code for every accepted input beat, and compares
// each output beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ptsn_checker import ptsn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_beat_i,
  output int        errors_o,
  output int        pending_o
);

  localparam longint CoordMax = (64'sd1 <<< (CoordBits - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  localparam longint DistMax  = (64'sd1 <<< DistW) - 1;

  out_beat_t nearest_q[$];

  // d * dap / dab, rounded half away from zero; dab > 0
  function automatic longint foot_offset(longint d, longint dap, longint dab);
    logic [127:0] num, quo, rem;
    longint ud, um;
    ud  = (d < 0) ? -d : d;
    um  = (dap < 0) ? -dap : dap;
    num = 128'(ud) * 128'(um);
    quo = num / 128'(dab);
    rem = num % 128'(dab);
    if (2 * rem >= 128'(dab)) quo = quo + 1;
    return ((d < 0) != (dap < 0)) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint round_sqrt(logic [127:0] v);
    logic [127:0] s, c;
    s = 0;
    for (int b = 52; b >= 0; b--) begin
      c = s | (128'd1 << b);
      if (c * c <= v) s = c;
    end
    if (s * s + s < v) s = s + 1;
    return longint'(s);
  endfunction

  function automatic longint clip_coord(longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic out_beat_t nearest_point(in_beat_t b);
    out_beat_t r;
    longint ax, ay, bx, by, qx, qy, dx, dy, px, py, dap, dab, nx, ny, ex, ey, span;
    case_e code;
    ax = b.start_x; ay = b.start_y; bx = b.end_x; by = b.end_y;
    qx = b.query_x; qy = b.query_y;
    dx = bx - ax; dy = by - ay; px = qx - ax; py = qy - ay;
    dap = px * dx + py * dy;
    dab = dx * dx + dy * dy;
    if (b.clamp_to_segment && dap <= 0) begin
      nx = ax; ny = ay; code = CaseClampA;
    end else if (b.clamp_to_segment && dap >= dab) begin
      nx = bx; ny = by; code = CaseClampB;
    end else if (dab == 0) begin
      nx = ax; ny = ay; code = CaseDegenerate;
    end else begin
      nx = ax + foot_offset(dx, dap, dab);
      ny = ay + foot_offset(dy, dap, dab);
      code = CaseInterior;
    end
    ex = nx - qx; ey = ny - qy;
    span = round_sqrt(128'(ex * ex) + 128'(ey * ey));
    if (span > DistMax) span = DistMax;
    r.nearest_x = CoordBits'(clip_coord(nx));
    r.nearest_y = CoordBits'(clip_coord(ny));
    r.distance  = DistW'(span);
    r.case_code = code;
    return r;
  endfunction

  int errors;
  assign errors_o  = errors;
  assign pending_o = nearest_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      errors = 0;
    end else begin
      if (in_valid_i && in_ready_i) nearest_q.push_back(nearest_point(in_beat_i));
      if (out_valid_i && out_ready_i) begin
        if (nearest_q.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_beat_i);
          errors++;
        end else begin
          want = nearest_q.pop_front();
          if (out_beat_i.nearest_x !== want.nearest_x) begin
            $display("%0t: nearest_x exp %0d got %0d", $time, want.nearest_x,
                     out_beat_i.nearest_x);
            errors++;
          end
          if (out_beat_i.nearest_y !== want.nearest_y) begin
            $display("%0t: nearest_y exp %0d got %0d", $time, want.nearest_y,
                     out_beat_i.nearest_y);
            errors++;
          end
          if (out_beat_i.distance !== want.distance) begin
            $display("%0t: distance exp %0d got %0d", $time, want.distance,
                     out_beat_i.distance);
            errors++;
          end
          if (out_beat_i.case_code !== want.case_code) begin
            $display("%0t: case_code exp %0d got %0d", $time, want.case_code,
                     out_beat_i.case_code);
            errors++;
          end
        end
      end
    end
  end

endmodule

### test/tb_point_to_segment_nearest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_to_segment_nearest
// Drives directed and random segment queries through the nearest-point
// pipeline with random idling on both sides, a long output hold-off and a
// drain pause; ptsn_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_point_to_segment_nearest import ptsn_pkg::*;;

  localparam int NumRandom = 1280;
  localparam int StallLimit = 3000;
  localparam logic signed [CoordBits-1:0] Max = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] Min = {1'b1, {(CoordBits-1){1'b0}}};

  logic      clk_i, rst_ni;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_beat_t  in_beat;
  out_beat_t out_beat;
  int        errors, pending;
  logic      quiet, hold_req;

  point_to_segment_nearest dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_beat_i(in_beat),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_beat_o(out_beat)
  );

  ptsn_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_beat_i(in_beat),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_beat_i(out_beat),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [CoordBits-1:0] coord(int span);
    if (span == 0) return CoordBits'($urandom);
    return CoordBits'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic in_beat_t random_query();
    in_beat_t b;
    int span, m;
    m = $urandom_range(0, 9);
    span = (m < 3) ? 0 : (m < 6) ? 255 : (m < 8) ? 40000 : 3;
    b.start_x = coord(span); b.start_y = coord(span);
    b.end_x   = coord(span); b.end_y   = coord(span);
    b.query_x = coord(span); b.query_y = coord(span);
    b.clamp_to_segment = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 11))
      0: begin b.end_x = b.start_x; b.end_y = b.start_y; end
      1: begin b.query_x = b.start_x; b.query_y = b.start_y; end
      2: begin b.query_x = b.end_x; b.query_y = b.end_y; end
      default: ;
    endcase
    return b;
  endfunction

  function automatic in_beat_t mk(logic signed [CoordBits-1:0] ax, ay, bx, by, qx, qy,
                                  logic c);
    in_beat_t b;
    b.start_x = ax; b.start_y = ay; b.end_x = bx; b.end_y = by;
    b.query_x = qx; b.query_y = qy; b.clamp_to_segment = c;
    return b;
  endfunction

  task automatic send(in_beat_t b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else if (rst_ni && (in_valid || pending != 0)) idle++;
      if (idle >= StallLimit) begin
        $display("tb_point_to_segment_nearest: errors");
        $finish;
      end
    end
  end

  initial begin
    quiet = 1'b0; hold_req = 1'b0;
    in_valid <= 1'b0;
    in_beat  <= '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int c = 0; c < 2; c++) begin
      send(mk(0, 0, 256, 0, 128, 100, 1'(c)));
      send(mk(0, 0, 256, 0, -50, 70, 1'(c)));
      send(mk(0, 0, 256, 0, 900, -70, 1'(c)));
      send(mk(10, 20, 10, 20, 500, -300, 1'(c)));
      send(mk(Min, Min, Max, Max, Max, Min, 1'(c)));
      send(mk(Max, Min, Min, Max, Min, Min, 1'(c)));
      send(mk(Min, Min, Min, Min, Max, Max, 1'(c)));
      send(mk(Max, Max, Max, Max, Max, Max, 1'(c)));
      send(mk(Min, 0, Min + 1, 0, Max, Max, 1'(c)));
      send(mk(-1000, -1000, 1000, 1000, 0, 0, 1'(c)));
      send(mk(5, 5, 1, 3, 5, 5, 1'(c)));
      send(mk(0, 0, 3, 1, 1, 1, 1'(c)));
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == 700) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (i == NumRandom - 150) quiet = 1'b1;
      send(random_query());
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_point_to_segment_nearest: clean");
    end else begin
      $display("tb_point_to_segment_nearest: errors");
    end
    $finish;
  end

endmodule

### point_to_segment_nearest.f
rtl/ptsn_pkg.sv
rtl/ptsn_front.sv
rtl/ptsn_div_cell.sv
rtl/ptsn_mid.sv
rtl/ptsn_sqrt_cell.sv
rtl/point_to_segment_nearest.sv
test/ptsn_checker.sv
test/tb_point_to_segment_nearest.sv
